// ===== hdl/b64d_pkg.sv =====
// Shared types and constants of the base64url decoder.
package b64d_pkg;

    localparam int CAP_W = 24;

    // Result status codes
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_BAD_LEN   = 2'd1;
    localparam logic [1:0] ST_TOO_SMALL = 2'd2;
    localparam logic [1:0] ST_BAD_CHAR  = 2'd3;

    // Configuration register index, taken from paddr[2]
    localparam logic REG_OUT_CAPACITY = 1'b0;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       byte_valid;
        logic       is_final;
        logic [1:0] status;
    } res_t;

    // Up to three output words caused by one character; entry 0 leaves first.
    typedef struct packed {
        logic [1:0]     cnt;
        res_t [2:0]     r;
    } bundle_t;

endpackage

// ===== hdl/b64d_if.sv =====
// Valid/ready channel interfaces for encoded characters and decoded words.
interface b64d_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_char;
    logic       is_last;

    modport source (output valid, output in_char, output is_last, input ready);
    modport sink (input valid, input in_char, input is_last, output ready);
endinterface

interface b64d_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       is_final;
    logic [1:0] status;

    modport source (output valid, output out_byte, output byte_valid, output is_final,
                    output status, input ready);
    modport sink (input valid, input out_byte, input byte_valid, input is_final,
                  input status, output ready);
endinterface

// ===== hdl/b64d_core.sv =====
// Input register, group state and single-pass decode of one character.
module b64d_core #(
    parameter int COUNT_WIDTH = 24
) (
    input  logic                         clk,
    input  logic                         rst_n,
    b64d_in_if.sink                      in_ch,
    input  logic [b64d_pkg::CAP_W-1:0]   cap,
    input  logic                         take_ok,
    output logic                         push,
    output b64d_pkg::bundle_t            bundle
);

    localparam int CMP_W = (COUNT_WIDTH + 2 > b64d_pkg::CAP_W) ?
                           COUNT_WIDTH + 2 : b64d_pkg::CAP_W;

    typedef enum logic [1:0] {KIND_DATA, KIND_PAD, KIND_BAD} kind_t;

    logic                   ivld_reg;
    logic [7:0]             ichar_reg;
    logic                   ilast_reg;

    logic [1:0]             pos_reg, pos_next;
    logic [17:0]            sext_reg, sext_next;
    logic [2:0]             pad_reg, pad_next;
    logic [2:0]             bad_reg, bad_next;
    logic [COUNT_WIDTH-1:0] gcnt_reg, gcnt_next;
    logic                   seen_reg, seen_next;

    kind_t                  kind;
    logic [5:0]             v3;
    logic [23:0]            triple;
    logic [COUNT_WIDTH:0]   inc;
    logic [CMP_W-1:0]       need3;
    logic [CMP_W-1:0]       cap_x;
    logic                   advance;

    always_comb
    begin
        kind = KIND_BAD;
        v3   = 6'd0;
        if (ichar_reg >= 8'h41 && ichar_reg <= 8'h5A)
        begin
            kind = KIND_DATA;
            v3   = 6'(ichar_reg - 8'h41);
        end
        else if (ichar_reg >= 8'h61 && ichar_reg <= 8'h7A)
        begin
            kind = KIND_DATA;
            v3   = 6'(ichar_reg - 8'h61 + 8'd26);
        end
        else if (ichar_reg >= 8'h30 && ichar_reg <= 8'h39)
        begin
            kind = KIND_DATA;
            v3   = 6'(ichar_reg - 8'h30 + 8'd52);
        end
        else if (ichar_reg == 8'h2D)
        begin
            kind = KIND_DATA;
            v3   = 6'd62;
        end
        else if (ichar_reg == 8'h5F)
        begin
            kind = KIND_DATA;
            v3   = 6'd63;
        end
        else if (ichar_reg == 8'h3D)
        begin
            kind = KIND_PAD;
        end
    end

    assign triple = {sext_reg, v3};
    assign inc    = {1'b0, gcnt_reg} + {{COUNT_WIDTH{1'b0}}, 1'b1};
    assign need3  = CMP_W'(inc) + CMP_W'({inc, 1'b0});
    assign cap_x  = CMP_W'(cap);

    always_comb
    begin
        logic       p1;
        logic       p2;
        logic       p3;
        logic [1:0] padc;
        logic [2:0] notdata;
        logic [1:0] st;
        logic [1:0] nb;
        logic [5:0] v1;
        logic [5:0] v2;

        p1      = pad_reg[1];
        p2      = pad_reg[2];
        p3      = (kind == KIND_PAD);
        padc    = 2'(p2) + 2'(p3);
        notdata = pad_reg | bad_reg;
        v1      = sext_reg[11:6];
        v2      = sext_reg[5:0];
        st      = b64d_pkg::ST_OK;
        nb      = 2'd0;

        pos_next  = pos_reg;
        sext_next = sext_reg;
        pad_next  = pad_reg;
        bad_next  = bad_reg;
        gcnt_next = gcnt_reg;
        seen_next = seen_reg;

        bundle = '0;

        if (!ilast_reg)
        begin
            if (pos_reg != 2'd3)
            begin
                unique case (pos_reg)
                    2'd0:    sext_next[17:12] = v3;
                    2'd1:    sext_next[11:6]  = v3;
                    default: sext_next[5:0]   = v3;
                endcase
                if (kind == KIND_PAD)
                begin
                    pad_next[pos_reg] = 1'b1;
                end
                if (kind == KIND_BAD)
                begin
                    bad_next[pos_reg] = 1'b1;
                end
                pos_next = pos_reg + 2'd1;
            end
            else
            begin
                seen_next = seen_reg || (notdata != 3'd0) || (kind != KIND_DATA);
                if (!seen_next && need3 <= cap_x)
                begin
                    bundle.cnt  = 2'd3;
                    bundle.r[0] = '{triple[23:16], 1'b1, 1'b0, b64d_pkg::ST_OK};
                    bundle.r[1] = '{triple[15:8], 1'b1, 1'b0, b64d_pkg::ST_OK};
                    bundle.r[2] = '{triple[7:0], 1'b1, 1'b0, b64d_pkg::ST_OK};
                end
                if (gcnt_reg != {COUNT_WIDTH{1'b1}})
                begin
                    gcnt_next = inc[COUNT_WIDTH-1:0];
                end
                pos_next  = 2'd0;
                sext_next = '0;
                pad_next  = '0;
                bad_next  = '0;
            end
        end
        else
        begin
            priority if (pos_reg != 2'd3)
            begin
                st = b64d_pkg::ST_BAD_LEN;
            end
            else if (!p3 && p2)
            begin
                st = b64d_pkg::ST_BAD_LEN;
            end
            else if (padc == 2'd2 && p1)
            begin
                st = b64d_pkg::ST_BAD_LEN;
            end
            else if (need3 - CMP_W'(padc) > cap_x)
            begin
                st = b64d_pkg::ST_TOO_SMALL;
            end
            else if (seen_reg || notdata[1:0] != 2'd0)
            begin
                st = b64d_pkg::ST_BAD_CHAR;
            end
            else if (padc == 2'd2)
            begin
                if (v1[3:0] != 4'd0)
                begin
                    st = b64d_pkg::ST_BAD_LEN;
                end
                else
                begin
                    nb = 2'd1;
                end
            end
            else if (padc == 2'd1)
            begin
                if (notdata[2])
                begin
                    st = b64d_pkg::ST_BAD_CHAR;
                end
                else if (v2[1:0] != 2'd0)
                begin
                    st = b64d_pkg::ST_BAD_LEN;
                end
                else
                begin
                    nb = 2'd2;
                end
            end
            else
            begin
                if (notdata[2] || kind != KIND_DATA)
                begin
                    st = b64d_pkg::ST_BAD_CHAR;
                end
                else
                begin
                    nb = 2'd3;
                end
            end

            if (st != b64d_pkg::ST_OK || nb == 2'd0)
            begin
                bundle.cnt  = 2'd1;
                bundle.r[0] = '{8'd0, 1'b0, 1'b1, st};
            end
            else
            begin
                bundle.cnt  = nb;
                bundle.r[0] = '{triple[23:16], 1'b1, (nb == 2'd1), b64d_pkg::ST_OK};
                bundle.r[1] = '{triple[15:8], 1'b1, (nb == 2'd2), b64d_pkg::ST_OK};
                bundle.r[2] = '{triple[7:0], 1'b1, (nb == 2'd3), b64d_pkg::ST_OK};
            end

            pos_next  = 2'd0;
            sext_next = '0;
            pad_next  = '0;
            bad_next  = '0;
            gcnt_next = '0;
            seen_next = 1'b0;
        end
    end

    // A character that yields no word moves on even while the buffer is full.
    assign advance      = ivld_reg && (bundle.cnt == 2'd0 || take_ok);
    assign push         = advance && (bundle.cnt != 2'd0);
    assign in_ch.ready  = !ivld_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ivld_reg <= 1'b0;
            pos_reg  <= '0;
            sext_reg <= '0;
            pad_reg  <= '0;
            bad_reg  <= '0;
            gcnt_reg <= '0;
            seen_reg <= 1'b0;
        end
        else
        begin
            if (in_ch.ready)
            begin
                ivld_reg <= in_ch.valid;
            end
            if (advance)
            begin
                pos_reg  <= pos_next;
                sext_reg <= sext_next;
                pad_reg  <= pad_next;
                bad_reg  <= bad_next;
                gcnt_reg <= gcnt_next;
                seen_reg <= seen_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ch.valid && in_ch.ready)
        begin
            ichar_reg <= in_ch.in_char;
            ilast_reg <= in_ch.is_last;
        end
    end

endmodule

// ===== hdl/b64d_outbuf.sv =====
// Result register of up to three words, sent one per cycle on ready.
module b64d_outbuf (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  b64d_pkg::bundle_t bundle,
    output logic              take_ok,
    b64d_out_if.source        out_ch
);

    logic [1:0]           cnt_reg;
    b64d_pkg::res_t [2:0] res_reg;
    logic                 pop;

    assign pop     = (cnt_reg != 2'd0) && out_ch.ready;
    assign take_ok = (cnt_reg == 2'd0) || (cnt_reg == 2'd1 && pop);

    assign out_ch.valid      = (cnt_reg != 2'd0);
    assign out_ch.out_byte   = res_reg[0].out_byte;
    assign out_ch.byte_valid = res_reg[0].byte_valid;
    assign out_ch.is_final   = res_reg[0].is_final;
    assign out_ch.status     = res_reg[0].status;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= 2'd0;
        end
        else if (push)
        begin
            cnt_reg <= bundle.cnt;
        end
        else if (pop)
        begin
            cnt_reg <= cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            res_reg <= bundle.r;
        end
        else if (pop)
        begin
            res_reg[0] <= res_reg[1];
            res_reg[1] <= res_reg[2];
        end
    end

endmodule

// ===== hdl/base64url_padded_decoder.sv =====
// A character is held in the input register; its words leave from the result register.
// Throughput: one character per cycle unless its words wait for buffer room; one word per
// cycle while the output is ready. Four characters give at most three words, so a steady
// stream never stalls; a finished final group of three words followed at once by another
// worded character stalls input. Reset: asynchronous, active low; clears group state,
// buffers and sets out_capacity to its maximum. No memory needs clearing, so words are taken straight after reset.
module base64url_padded_decoder #(
    parameter int COUNT_WIDTH = 24
) (
    input  logic        clk,
    input  logic        rst_n,
    b64d_in_if.sink     in_ch,
    b64d_out_if.source  out_ch,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [b64d_pkg::CAP_W-1:0] cap_reg;
    logic                       take_ok;
    logic                       push;
    b64d_pkg::bundle_t          bundle;
    logic                       cap_sel;

    assign pready  = 1'b1;
    assign cap_sel = (paddr[2] == b64d_pkg::REG_OUT_CAPACITY);
    assign prdata  = cap_sel ? {{(32 - b64d_pkg::CAP_W){1'b0}}, cap_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg <= {b64d_pkg::CAP_W{1'b1}};
        end
        else if (psel && penable && pwrite && pready && cap_sel)
        begin
            cap_reg <= pwdata[b64d_pkg::CAP_W-1:0];
        end
    end

    b64d_core #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_ch   (in_ch),
        .cap     (cap_reg),
        .take_ok (take_ok),
        .push    (push),
        .bundle  (bundle)
    );

    b64d_outbuf u_outbuf (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .bundle  (bundle),
        .take_ok (take_ok),
        .out_ch  (out_ch)
    );

    // Any fault status comes on a final word that carries no byte.
    a_err_no_byte: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid && out_ch.status != b64d_pkg::ST_OK |-> out_ch.is_final && !out_ch.byte_valid)
        else $error("fault status on a non-final or data word");

    // A word without data is always the final word of a string.
    a_nodata_final: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid && !out_ch.byte_valid |-> out_ch.is_final)
        else $error("empty word that is not final");

    // A new group of words only loads once the buffer is free.
    a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> take_ok && bundle.cnt != 2'd0)
        else $error("words loaded into an occupied buffer");

    // A word that is not taken stays on the output unchanged.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid && !out_ch.ready |=> out_ch.valid &&
            $stable({out_ch.out_byte, out_ch.byte_valid, out_ch.is_final, out_ch.status}))
        else $error("waiting word changed or dropped");

endmodule

// ===== tb/base64url_padded_decoder_tb.sv =====
// Self-checking testbench for the base64url decoder, with its own decode predictor.
`timescale 1ns / 1ps

module base64url_padded_decoder_tb;

    localparam int CNT_W = 24;
    localparam int RUN_LIMIT_NS = 1000000;

    typedef enum logic [1:0] {CH_DATA, CH_PAD, CH_BAD} char_kind_t;

    typedef struct packed {
        logic [7:0] ch;
        logic       last;
    } enc_char_t;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    b64d_in_if  in_ch ();
    b64d_out_if out_ch ();

    base64url_padded_decoder #(.COUNT_WIDTH(CNT_W)) i_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_ch   (in_ch),
        .out_ch  (out_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Decoder state as the predictor sees it
    logic [b64d_pkg::CAP_W-1:0] cap_bytes;
    logic [1:0]                 grp_pos;
    logic [17:0]                grp_sextets;
    logic [2:0]                 pad_flags;
    logic [2:0]                 bad_flags;
    logic [CNT_W-1:0]           grp_cnt;
    logic                       bad_seen;

    enc_char_t       char_q[$];
    b64d_pkg::res_t  exp_words[$];
    enc_char_t       nxt;
    b64d_pkg::res_t  got;
    b64d_pkg::res_t  want;
    int        chars_queued = 0;
    int        words_seen = 0;
    int        errors = 0;
    int        in_gap = 0;
    int        out_stall = 0;
    int        calm[2] = '{0, 0};
    bit        in_taken = 1'b0;

    task report(input string msg);
        errors++;
        if (errors <= 40)
        begin
            $display("ERROR at %0t ns: %s", $time, msg);
        end
    endtask

    // Idle length for one side (0 sender, 1 receiver); now and then a calm stretch.
    function int idle_len(input int side);
        int r;
        if (calm[side] > 0)
        begin
            calm[side]--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 3)
        begin
            calm[side] = $urandom_range(20, 80);
            return 0;
        end
        if (r < 60)
        begin
            return 0;
        end
        if (r < 92)
        begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(6, 25);
    endfunction

    function char_kind_t classify(input logic [7:0] c, output logic [5:0] v);
        v = 6'd0;
        if (c >= "A" && c <= "Z")
        begin
            v = 6'(c - "A");
            return CH_DATA;
        end
        if (c >= "a" && c <= "z")
        begin
            v = 6'(c - "a" + 26);
            return CH_DATA;
        end
        if (c >= "0" && c <= "9")
        begin
            v = 6'(c - "0" + 52);
            return CH_DATA;
        end
        if (c == "-")
        begin
            v = 6'd62;
            return CH_DATA;
        end
        if (c == "_")
        begin
            v = 6'd63;
            return CH_DATA;
        end
        if (c == "=")
        begin
            return CH_PAD;
        end
        return CH_BAD;
    endfunction

    function logic [7:0] sextet_char(input logic [5:0] v);
        if (v < 26)
        begin
            return 8'("A" + v);
        end
        if (v < 52)
        begin
            return 8'("a" + v - 26);
        end
        if (v < 62)
        begin
            return 8'("0" + v - 52);
        end
        return (v == 6'd62) ? 8'("-") : 8'("_");
    endfunction

    function void clear_group();
        grp_pos = 2'd0;
        grp_sextets = 18'd0;
        pad_flags = 3'd0;
        bad_flags = 3'd0;
    endfunction

    // Works out the words that one accepted character gives and queues them.
    task decode_char(input logic [7:0] c, input logic last);
        char_kind_t  kind;
        logic [5:0]  v;
        logic [5:0]  v1;
        logic [5:0]  v2;
        logic [23:0] triple;
        logic [2:0]  notdata;
        logic [1:0]  st;
        logic        p1;
        logic        p2;
        logic        p3;
        int          padc;
        int          nbytes;
        longint      need;
        kind = classify(c, v);
        triple = {grp_sextets, v};
        if (!last)
        begin
            if (grp_pos < 2'd3)
            begin
                grp_sextets |= 18'(v) << (12 - 6 * grp_pos);
                if (kind == CH_PAD)
                begin
                    pad_flags[grp_pos] = 1'b1;
                end
                if (kind == CH_BAD)
                begin
                    bad_flags[grp_pos] = 1'b1;
                end
                grp_pos++;
            end
            else
            begin
                if (pad_flags != 3'd0 || bad_flags != 3'd0 || kind != CH_DATA)
                begin
                    bad_seen = 1'b1;
                end
                if (!bad_seen && (longint'(grp_cnt) + 1) * 3 <= longint'(cap_bytes))
                begin
                    for (int i = 0; i < 3; i++)
                    begin
                        exp_words.push_back('{triple[23 - 8 * i -: 8], 1'b1, 1'b0,
                                              b64d_pkg::ST_OK});
                    end
                end
                if (grp_cnt != {CNT_W{1'b1}})
                begin
                    grp_cnt++;
                end
                clear_group();
            end
        end
        else
        begin
            st = b64d_pkg::ST_OK;
            nbytes = 0;
            if (grp_pos != 2'd3)
            begin
                st = b64d_pkg::ST_BAD_LEN;
            end
            else
            begin
                p1 = pad_flags[1];
                p2 = pad_flags[2];
                p3 = (kind == CH_PAD);
                padc = int'(p2) + int'(p3);
                notdata = pad_flags | bad_flags;
                v1 = grp_sextets[11:6];
                v2 = grp_sextets[5:0];
                need = (longint'(grp_cnt) + 1) * 3 - padc;
                if (!p3 && p2)
                begin
                    st = b64d_pkg::ST_BAD_LEN;
                end
                else if (padc == 2 && p1)
                begin
                    st = b64d_pkg::ST_BAD_LEN;
                end
                else if (need > longint'(cap_bytes))
                begin
                    st = b64d_pkg::ST_TOO_SMALL;
                end
                else if (bad_seen || notdata[1:0] != 2'd0)
                begin
                    st = b64d_pkg::ST_BAD_CHAR;
                end
                else if (padc == 2)
                begin
                    if (v1[3:0] != 4'd0)
                    begin
                        st = b64d_pkg::ST_BAD_LEN;
                    end
                    else
                    begin
                        nbytes = 1;
                    end
                end
                else if (padc == 1)
                begin
                    if (notdata[2])
                    begin
                        st = b64d_pkg::ST_BAD_CHAR;
                    end
                    else if (v2[1:0] != 2'd0)
                    begin
                        st = b64d_pkg::ST_BAD_LEN;
                    end
                    else
                    begin
                        nbytes = 2;
                    end
                end
                else if (notdata[2] || kind != CH_DATA)
                begin
                    st = b64d_pkg::ST_BAD_CHAR;
                end
                else
                begin
                    nbytes = 3;
                end
            end
            if (st != b64d_pkg::ST_OK || nbytes == 0)
            begin
                exp_words.push_back('{8'd0, 1'b0, 1'b1, st});
            end
            else
            begin
                for (int i = 0; i < nbytes; i++)
                begin
                    exp_words.push_back('{triple[23 - 8 * i -: 8], 1'b1,
                                          logic'(i == nbytes - 1), b64d_pkg::ST_OK});
                end
            end
            clear_group();
            grp_cnt = '0;
            bad_seen = 1'b0;
        end
    endtask

    // Output words are checked before the accepted character is predicted, so a
    // spurious word can never meet an expectation queued in the same cycle.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_ch.valid && out_ch.ready)
            begin
                got = '{out_ch.out_byte, out_ch.byte_valid, out_ch.is_final, out_ch.status};
                words_seen++;
                if (exp_words.size() == 0)
                begin
                    report($sformatf("word %0d arrived with nothing expected (%h)",
                                     words_seen, got));
                end
                else
                begin
                    want = exp_words.pop_front();
                    if (got.out_byte !== want.out_byte)
                    begin
                        report($sformatf("word %0d: out_byte %h, expected %h",
                                         words_seen, got.out_byte, want.out_byte));
                    end
                    if (got.byte_valid !== want.byte_valid)
                    begin
                        report($sformatf("word %0d: byte_valid %b, expected %b",
                                         words_seen, got.byte_valid, want.byte_valid));
                    end
                    if (got.is_final !== want.is_final)
                    begin
                        report($sformatf("word %0d: is_final %b, expected %b",
                                         words_seen, got.is_final, want.is_final));
                    end
                    if (got.status !== want.status)
                    begin
                        report($sformatf("word %0d: status %0d, expected %0d",
                                         words_seen, got.status, want.status));
                    end
                end
            end
            if (in_ch.valid && in_ch.ready)
            begin
                decode_char(in_ch.in_char, in_ch.is_last);
                in_taken = 1'b1;
            end
        end
    end

    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (!in_ch.valid || in_taken)
            begin
                in_taken = 1'b0;
                if (in_gap > 0)
                begin
                    in_gap--;
                    in_ch.valid <= 1'b0;
                end
                else if (char_q.size() > 0)
                begin
                    nxt = char_q.pop_front();
                    in_ch.valid <= 1'b1;
                    in_ch.in_char <= nxt.ch;
                    in_ch.is_last <= nxt.last;
                    in_gap = idle_len(0);
                end
                else
                begin
                    in_ch.valid <= 1'b0;
                end
            end
            if (out_stall > 0)
            begin
                out_stall--;
                out_ch.ready <= 1'b0;
            end
            else
            begin
                out_ch.ready <= 1'b1;
                out_stall = idle_len(1);
            end
        end
    end

    task push_char(input logic [7:0] c, input logic last);
        char_q.push_back('{c, last});
        chars_queued++;
    endtask

    task push_text(input string s, input bit ends);
        for (int i = 0; i < s.len(); i++)
        begin
            push_char(s[i], ends && (i == s.len() - 1));
        end
    endtask

    // Mostly well-formed strings with random content; the rest are corrupted or noise.
    task automatic add_random_string();
        logic [7:0] s[$];
        logic [5:0] v;
        int         mode;
        int         groups;
        int         padn;
        int         n;
        mode = $urandom_range(0, 99);
        groups = $urandom_range(1, 4);
        padn = $urandom_range(0, 2);
        if (mode >= 92)
        begin
            repeat ($urandom_range(1, 9))
            begin
                s.push_back(8'($urandom));
            end
        end
        else
        begin
            n = groups * 4;
            for (int g = 0; g < n; g++)
            begin
                v = 6'($urandom);
                if (g >= n - padn)
                begin
                    s.push_back(8'("="));
                end
                else
                begin
                    // Below 80 the unused low bits of the final group are kept clear.
                    if (mode < 80 && padn == 2 && g == n - 3)
                    begin
                        v[3:0] = 4'd0;
                    end
                    if (mode < 80 && padn == 1 && g == n - 2)
                    begin
                        v[1:0] = 2'd0;
                    end
                    s.push_back(sextet_char(v));
                end
            end
            if (mode >= 60 && mode < 70)
            begin
                s[$urandom_range(0, s.size() - 1)] = 8'($urandom);
            end
            else if (mode >= 70 && mode < 75)
            begin
                s[$urandom_range(0, s.size() - 1)] = 8'("=");
            end
            else if (mode >= 75 && mode < 80)
            begin
                if ($urandom_range(0, 1) == 0)
                begin
                    void'(s.pop_back());
                end
                else
                begin
                    s.push_back(sextet_char(6'($urandom)));
                end
            end
        end
        foreach (s[i])
        begin
            push_char(s[i], i == s.size() - 1);
        end
    endtask

    task wait_idle();
        while (char_q.size() != 0 || in_ch.valid || exp_words.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (4) @(posedge clk);
    endtask

    task write_capacity(input logic [b64d_pkg::CAP_W-1:0] value);
        @(negedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {b64d_pkg::REG_OUT_CAPACITY, 2'b00};
        pwdata <= 32'(value);
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
        begin
            @(posedge clk);
        end
        cap_bytes = value;
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task n_start_phase(input int until_count);
        while (chars_queued < until_count)
        begin
            add_random_string();
        end
    endtask

    initial
    begin
        logic [b64d_pkg::CAP_W-1:0] caps[6];
        rst_n = 1'b0;
        in_ch.valid = 1'b0;
        in_ch.in_char = 8'd0;
        in_ch.is_last = 1'b0;
        out_ch.ready = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = 3'd0;
        pwdata = 32'd0;
        cap_bytes = {b64d_pkg::CAP_W{1'b1}};
        clear_group();
        grp_cnt = '0;
        bad_seen = 1'b0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Extreme bytes, one and two pads, bad pad patterns, a non-alphabet
        // character beside a pad, and strings of the wrong length.
        push_text("____", 1'b0);
        push_text("AAAA", 1'b1);
        push_text("TQ==", 1'b1);
        push_text("TWE=", 1'b1);
        push_text("T===", 1'b1);
        push_char("T", 1'b0);
        push_char("W", 1'b0);
        push_char(8'hFF, 1'b0);
        push_char("=", 1'b1);
        push_text("TW=A", 1'b1);
        push_char(8'h00, 1'b1);
        while (chars_queued < 90)
        begin
            add_random_string();
        end
        wait_idle();

        // Small capacities put the byte limit inside the strings; the full value comes last.
        caps = '{24'd0, 24'd2, 24'd6, 24'($urandom_range(0, 12)),
                 24'(3 * $urandom_range(1, 4)), {b64d_pkg::CAP_W{1'b1}}};
        foreach (caps[k])
        begin
            write_capacity(caps[k]);
            n_start_phase(chars_queued + 40);
            wait_idle();
        end

        if (errors == 0)
        begin
            $display("tb: success");
        end
        else
        begin
            $display("tb: failure");
        end
        $finish;
    end

    initial
    begin
        #(RUN_LIMIT_NS);
        $display("tb: failure");
        $finish;
    end

endmodule
